>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define FDOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked while reset is released.
`define FDOT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/fdot_pkg.sv
// Shared types, codes and field layout of the job dispatch tracker.
package fdot_pkg;

  localparam int unsigned WAIT_DEPTH_DEF        = 64;
  localparam int unsigned OUTSTANDING_DEPTH_DEF = 64;

  localparam int unsigned OP_W      = 4;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned SUB_W     = 16;
  localparam int unsigned ENTRY_W   = ID_W + SUB_W;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned LIMIT_W   = 8;

  // Stream word layout, lowest field first.
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_FIELD_W = STATUS_W + 1 + ID_W + SUB_W + 2 * CNT_OUT_W;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int unsigned IN_OP_LSB  = 0;
  localparam int unsigned IN_ID_LSB  = IN_OP_LSB + OP_W;
  localparam int unsigned IN_SUB_LSB = IN_ID_LSB + ID_W;

  localparam int unsigned OUT_FOUND_BIT = STATUS_W;
  localparam int unsigned OUT_ID_LSB    = OUT_FOUND_BIT + 1;
  localparam int unsigned OUT_SUB_LSB   = OUT_ID_LSB + ID_W;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_PUSH_WAIT       = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_OUTSTANDING = 4'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH        = 4'd2;
  localparam logic [OP_W-1:0] OP_COMPLETE_ID     = 4'd3;
  localparam logic [OP_W-1:0] OP_COMPLETE_ID_SUB = 4'd4;
  localparam logic [OP_W-1:0] OP_COMPLETE_FRONT  = 4'd5;
  localparam logic [OP_W-1:0] OP_QUERY_ID        = 4'd6;
  localparam logic [OP_W-1:0] OP_QUERY_ID_SUB    = 4'd7;
  localparam logic [OP_W-1:0] OP_PEEK_WAIT       = 4'd8;
  localparam logic [OP_W-1:0] OP_PEEK_OUTSTANDING = 4'd9;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH_W,
    CMD_PUSH_O,
    CMD_RD_HEAD,
    CMD_DISPATCH,
    CMD_WALK_START,
    CMD_SCAN,
    CMD_SHIFT,
    CMD_MARK,
    CMD_DROP
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic                in_load;
    logic                res_we;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
    logic                res_from_wait;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            w_empty;
    logic            w_full;
    logic            o_full;
    logic            limit_hit;
    logic            match;
    logic            walk_done;
    logic            out_busy;
  } stat_t;

endpackage

>>> rtl/core/fdot_datapath.sv
// Datapath: wait queue memory, outstanding list memory, counters and result register.
module fdot_datapath #(
  parameter int unsigned WAIT_DEPTH        = fdot_pkg::WAIT_DEPTH_DEF,
  parameter int unsigned OUTSTANDING_DEPTH = fdot_pkg::OUTSTANDING_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fdot_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  logic [fdot_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  fdot_pkg::cmd_t                     cmd_i,
  output fdot_pkg::stat_t                    stat_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [fdot_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned WCW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned OAW = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;
  localparam int unsigned OCW = $clog2(OUTSTANDING_DEPTH + 1);

  localparam int unsigned ENTRY_W = fdot_pkg::ENTRY_W;
  localparam int unsigned ID_W    = fdot_pkg::ID_W;
  localparam int unsigned SUB_W   = fdot_pkg::SUB_W;

  // Latched request.
  logic [fdot_pkg::OP_W-1:0] op_q;
  logic [ID_W-1:0]           id_q;
  logic [SUB_W-1:0]          sub_q;

  logic [fdot_pkg::LIMIT_W-1:0] limit_q;

  logic [WAW-1:0] whead_q, wtail_q;
  logic [WCW-1:0] wsize_q;
  logic [OCW-1:0] osize_q;
  logic [OCW-1:0] ptr_q;
  logic           rv_q;
  logic [OAW-1:0] cmp_q;

  logic [ENTRY_W-1:0] wmem [WAIT_DEPTH];
  logic [ENTRY_W-1:0] omem [OUTSTANDING_DEPTH];
  logic [ENTRY_W-1:0] w_rdata_q;
  logic [ENTRY_W-1:0] o_rdata_q;

  logic [fdot_pkg::STATUS_W-1:0] res_status_q;
  logic                          res_found_q;
  logic [ID_W-1:0]               res_id_q;
  logic [SUB_W-1:0]              res_sub_q;

  logic                             out_valid_q;
  logic [fdot_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic           walk_rd;
  logic           any_match;
  logic           use_sub;
  logic           o_we;
  logic [OAW-1:0] o_waddr;
  logic [ENTRY_W-1:0] o_wdata;
  logic [ENTRY_W-1:0] res_src;
  logic [WAW-1:0] whead_next, wtail_next;

  assign whead_next = (whead_q == WAW'(WAIT_DEPTH - 1)) ? '0 : whead_q + WAW'(1);
  assign wtail_next = (wtail_q == WAW'(WAIT_DEPTH - 1)) ? '0 : wtail_q + WAW'(1);

  // A walk step reads one more outstanding entry while any remain.
  assign walk_rd = ((cmd_i.op == fdot_pkg::CMD_SCAN) || (cmd_i.op == fdot_pkg::CMD_SHIFT)) &&
                   (ptr_q < osize_q);

  assign any_match = (op_q == fdot_pkg::OP_COMPLETE_FRONT) ||
                     (op_q == fdot_pkg::OP_PEEK_OUTSTANDING);
  assign use_sub   = (op_q == fdot_pkg::OP_COMPLETE_ID_SUB) ||
                     (op_q == fdot_pkg::OP_QUERY_ID_SUB);

  always_comb begin
    stat_o.op        = op_q;
    stat_o.w_empty   = (wsize_q == '0);
    stat_o.w_full    = (wsize_q == WCW'(WAIT_DEPTH));
    stat_o.o_full    = (osize_q == OCW'(OUTSTANDING_DEPTH));
    stat_o.limit_hit = !limit_q[fdot_pkg::LIMIT_W-1] &&
                       (32'(osize_q) >= 32'(limit_q[fdot_pkg::LIMIT_W-2:0]));
    stat_o.match     = rv_q && (any_match ||
                       ((o_rdata_q[ID_W-1:0] == id_q) &&
                        (!use_sub || (o_rdata_q[ENTRY_W-1:ID_W] == sub_q))));
    stat_o.walk_done = !rv_q && (ptr_q >= osize_q);
    stat_o.out_busy  = out_valid_q && !m_axis_tready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q  <= in_data_i[fdot_pkg::IN_OP_LSB +: fdot_pkg::OP_W];
      id_q  <= in_data_i[fdot_pkg::IN_ID_LSB +: ID_W];
      sub_q <= in_data_i[fdot_pkg::IN_SUB_LSB +: SUB_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '1;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whead_q <= '0;
      wtail_q <= '0;
      wsize_q <= '0;
      osize_q <= '0;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        fdot_pkg::CMD_PUSH_W: begin
          wtail_q <= wtail_next;
          wsize_q <= wsize_q + WCW'(1);
        end
        fdot_pkg::CMD_PUSH_O: begin
          osize_q <= osize_q + OCW'(1);
        end
        fdot_pkg::CMD_DISPATCH: begin
          whead_q <= whead_next;
          wsize_q <= wsize_q - WCW'(1);
          osize_q <= osize_q + OCW'(1);
        end
        fdot_pkg::CMD_WALK_START: begin
          ptr_q <= '0;
          rv_q  <= 1'b0;
        end
        fdot_pkg::CMD_SCAN, fdot_pkg::CMD_SHIFT: begin
          if (walk_rd) begin
            ptr_q <= ptr_q + OCW'(1);
            rv_q  <= 1'b1;
          end else begin
            rv_q <= 1'b0;
          end
        end
        fdot_pkg::CMD_MARK: begin
          rv_q <= 1'b0;
        end
        fdot_pkg::CMD_DROP: begin
          osize_q <= osize_q - OCW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Wait queue: write at the tail, read the head into a register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == fdot_pkg::CMD_PUSH_W) begin
      wmem[wtail_q] <= {sub_q, id_q};
    end
    if (cmd_i.op == fdot_pkg::CMD_RD_HEAD) begin
      w_rdata_q <= wmem[whead_q];
    end
  end

  // During a shift, the entry read in the previous step moves down by one slot.
  always_comb begin
    o_we    = 1'b0;
    o_waddr = osize_q[OAW-1:0];
    o_wdata = {sub_q, id_q};
    case (cmd_i.op)
      fdot_pkg::CMD_PUSH_O: begin
        o_we = 1'b1;
      end
      fdot_pkg::CMD_DISPATCH: begin
        o_we    = 1'b1;
        o_wdata = w_rdata_q;
      end
      fdot_pkg::CMD_SHIFT: begin
        o_we    = rv_q;
        o_waddr = cmp_q - OAW'(1);
        o_wdata = o_rdata_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (o_we) begin
      omem[o_waddr] <= o_wdata;
    end
    if (walk_rd) begin
      o_rdata_q <= omem[ptr_q[OAW-1:0]];
      cmp_q     <= ptr_q[OAW-1:0];
    end
  end

  assign res_src = cmd_i.res_from_wait ? w_rdata_q : o_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_found;
      res_id_q     <= cmd_i.res_found ? res_src[ID_W-1:0] : '0;
      res_sub_q    <= cmd_i.res_found ? res_src[ENTRY_W-1:ID_W] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {{fdot_pkg::OUT_PAD_W{1'b0}},
                     fdot_pkg::CNT_OUT_W'(osize_q),
                     fdot_pkg::CNT_OUT_W'(wsize_q),
                     res_sub_q, res_id_q, res_found_q, res_status_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> rtl/core/fdot_ctrl.sv
// Controller: sequences each request through decode, memory reads, list walk and shift.
module fdot_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  fdot_pkg::stat_t stat_i,
  output fdot_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DISP   = 3'd2;
  localparam logic [2:0] S_PEEKW  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       removes;
  logic       front_op;

  assign removes  = (stat_i.op == fdot_pkg::OP_COMPLETE_ID) ||
                    (stat_i.op == fdot_pkg::OP_COMPLETE_ID_SUB) ||
                    (stat_i.op == fdot_pkg::OP_COMPLETE_FRONT);
  assign front_op = (stat_i.op == fdot_pkg::OP_COMPLETE_FRONT) ||
                    (stat_i.op == fdot_pkg::OP_PEEK_OUTSTANDING);

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d             = state_q;
    cmd_o.op            = fdot_pkg::CMD_NONE;
    cmd_o.in_load       = 1'b0;
    cmd_o.res_we        = 1'b0;
    cmd_o.res_status    = fdot_pkg::ST_OK;
    cmd_o.res_found     = 1'b0;
    cmd_o.res_from_wait = 1'b0;
    cmd_o.out_load      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_we = 1'b1;
        state_d      = S_DONE;
        case (stat_i.op)
          fdot_pkg::OP_PUSH_WAIT: begin
            if (stat_i.w_full) begin
              cmd_o.res_status = fdot_pkg::ST_FULL;
            end else begin
              cmd_o.op = fdot_pkg::CMD_PUSH_W;
            end
          end
          fdot_pkg::OP_PUSH_OUTSTANDING: begin
            if (stat_i.o_full) begin
              cmd_o.res_status = fdot_pkg::ST_FULL;
            end else begin
              cmd_o.op = fdot_pkg::CMD_PUSH_O;
            end
          end
          fdot_pkg::OP_DISPATCH: begin
            if (stat_i.w_empty) begin
              cmd_o.res_status = fdot_pkg::ST_EMPTY;
            end else if (stat_i.limit_hit) begin
              cmd_o.res_status = fdot_pkg::ST_LIMIT;
            end else if (stat_i.o_full) begin
              cmd_o.res_status = fdot_pkg::ST_FULL;
            end else begin
              cmd_o.res_we = 1'b0;
              cmd_o.op     = fdot_pkg::CMD_RD_HEAD;
              state_d      = S_DISP;
            end
          end
          fdot_pkg::OP_PEEK_WAIT: begin
            if (stat_i.w_empty) begin
              cmd_o.res_status = fdot_pkg::ST_EMPTY;
            end else begin
              cmd_o.res_we = 1'b0;
              cmd_o.op     = fdot_pkg::CMD_RD_HEAD;
              state_d      = S_PEEKW;
            end
          end
          fdot_pkg::OP_COMPLETE_ID, fdot_pkg::OP_COMPLETE_ID_SUB,
          fdot_pkg::OP_COMPLETE_FRONT, fdot_pkg::OP_QUERY_ID,
          fdot_pkg::OP_QUERY_ID_SUB, fdot_pkg::OP_PEEK_OUTSTANDING: begin
            cmd_o.res_we = 1'b0;
            cmd_o.op     = fdot_pkg::CMD_WALK_START;
            state_d      = S_SCAN;
          end
          default: begin
          end
        endcase
      end
      S_DISP: begin
        cmd_o.op            = fdot_pkg::CMD_DISPATCH;
        cmd_o.res_we        = 1'b1;
        cmd_o.res_found     = 1'b1;
        cmd_o.res_from_wait = 1'b1;
        state_d             = S_DONE;
      end
      S_PEEKW: begin
        cmd_o.res_we        = 1'b1;
        cmd_o.res_found     = 1'b1;
        cmd_o.res_from_wait = 1'b1;
        state_d             = S_DONE;
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.res_we    = 1'b1;
          cmd_o.res_found = 1'b1;
          if (removes) begin
            cmd_o.op = fdot_pkg::CMD_MARK;
            state_d  = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end else if (stat_i.walk_done) begin
          // Front operations only miss when the list is empty.
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = front_op ? fdot_pkg::ST_EMPTY : fdot_pkg::ST_NOTFOUND;
          state_d          = S_DONE;
        end else begin
          cmd_o.op = fdot_pkg::CMD_SCAN;
        end
      end
      S_SHIFT: begin
        if (stat_i.walk_done) begin
          cmd_o.op = fdot_pkg::CMD_DROP;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = fdot_pkg::CMD_SHIFT;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/fifo_dispatch_outstanding_tracker_unit.sv
// Top level of the job dispatch tracker: wait FIFO plus ordered outstanding list.
//
//   Channel   Direction  Signals                       Content
//   s_axis    in         tvalid/tready/tdata[55:0]     one request transaction
//   m_axis    out        tvalid/tready/tdata[71:0]     one result transaction
//   cfg       in         cfg_we_i/cfg_wdata_i[7:0]     outstanding limit register
//
// Pushes and unused opcodes go from acceptance through decode to the result;
// dispatch and wait peeks first read the wait memory head into a register.
// Searches and front operations walk the outstanding memory one entry per cycle,
// and a completion then shifts the tail of the list down by one slot. Reset needs
// no clearing pass. A result waits in the output register while the next request
// is accepted.
module fifo_dispatch_outstanding_tracker_unit #(
  parameter int unsigned WAIT_DEPTH        = fdot_pkg::WAIT_DEPTH_DEF,
  parameter int unsigned OUTSTANDING_DEPTH = fdot_pkg::OUTSTANDING_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fdot_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // opcode[3:0], job_id[35:4], job_sub_id[51:36], zero[55:52]
  input  logic [fdot_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status[2:0], found[3], out_job_id[35:4], out_sub_id[51:36],
  // wait_count[58:52], outstanding_count[65:59], zero[71:66]
  output logic [fdot_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  fdot_pkg::cmd_t  cmd;
  fdot_pkg::stat_t stat;

  fdot_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  fdot_datapath #(
    .WAIT_DEPTH        (WAIT_DEPTH),
    .OUTSTANDING_DEPTH (OUTSTANDING_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_data_i       (s_axis_tdata_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/core/fdot_checker.sv
// Port-level checker for the job dispatch tracker, bound to the top level.
`include "assert_macros.svh"

module fdot_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [fdot_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic                          res_found;
  logic [fdot_pkg::STATUS_W-1:0] res_status;
  logic [fdot_pkg::ID_W-1:0]     res_id;
  logic [fdot_pkg::SUB_W-1:0]    res_sub;

  assign res_status = m_axis_tdata_o[fdot_pkg::STATUS_W-1:0];
  assign res_found  = m_axis_tdata_o[fdot_pkg::OUT_FOUND_BIT];
  assign res_id     = m_axis_tdata_o[fdot_pkg::OUT_ID_LSB +: fdot_pkg::ID_W];
  assign res_sub    = m_axis_tdata_o[fdot_pkg::OUT_SUB_LSB +: fdot_pkg::SUB_W];

  // A stalled result stays offered.
  `FDOT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // Requests are handled one at a time.
  `FDOT_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // A returned job always comes with an ok status.
  `FDOT_ASSERT_IMP(a_found_ok, clk_i, rst_ni, m_axis_tvalid_o && res_found, res_status == fdot_pkg::ST_OK)

  // Without a returned job the job fields read as zero.
  `FDOT_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, m_axis_tvalid_o && !res_found, (res_id == '0) && (res_sub == '0))

endmodule

bind fifo_dispatch_outstanding_tracker_unit fdot_checker u_fdot_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
